// ===== rtl/u8u16_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_UNIT       = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_BAD_CONT   = 3'd2,
    ST_BAD_SCALAR = 3'd3,
    ST_TRUNC      = 3'd4
  } status_e;

  // result queue geometry (depth is a power of two)
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // code point limits and UTF-16 fields
  localparam logic [20:0] MaxScalar = 21'h10ffff;
  localparam logic [20:0] SurLo     = 21'h00d800;
  localparam logic [20:0] SurHi     = 21'h00dfff;
  localparam logic [20:0] PlaneOne  = 21'h010000;
  localparam logic [5:0]  HiSurTag  = 6'b110110;  // 0xd800 >> 10
  localparam logic [5:0]  LoSurTag  = 6'b110111;  // 0xdc00 >> 10

  typedef struct packed {
    logic [15:0] code_unit;
    status_e     status;
    logic        run_last;
    logic        string_done;
  } res_t;

  // decoder to queue: up to two results per byte
  typedef struct packed {
    logic [1:0] n_res;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

endpackage
`default_nettype wire

// ===== rtl/u8u16_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte channel: one UTF-8 byte and its end-of-string flag per beat.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       string_end;

  modport source (output valid, output byte_in, output string_end, input ready);
  modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/u8u16_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_out_if
// Result channel: one UTF-16 unit or error status per beat.
// ----------------------------------------------------------------------------
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  status;
  logic        run_last;
  logic        string_done;

  modport source (output valid, output code_unit, output status, output run_last,
                  output string_done, input ready);
  modport sink   (input valid, input code_unit, input status, input run_last,
                  input string_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/utf8_to_utf16_transcoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Strict UTF-8 to UTF-16 transcoder, one byte per beat in, one unit out.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_i     in   byte_in[7:0], string_end
//  out_o    out  code_unit[15:0], status[2:0], run_last, string_done
//
//  Throughput: one byte per cycle while the result queue has room; results
//  leave at one per cycle while out_o.ready is high, so a byte that makes a
//  surrogate pair puts both halves on the output port in turn.
//  Path: a byte passes the input register, then decode into the result queue;
//  a queue without room for a pair holds the byte in the input register.
//  Stalls: a four-entry result queue decouples the sides; the byte register
//  only drains into the queue when it has room for a full pair.
//  Reset: asynchronous, clears decode state and queue pointers.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  u8u16_in_if.sink      in_i,
  u8u16_out_if.source   out_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  logic                  room;
  logic                  dec_go;
  u8u16_pkg::dec_out_t   dec_res;
  u8u16_pkg::res_t       q_data;

  // byte register drains into the decoder when the queue can take a pair
  assign dec_go     = in_vld_q && room;
  assign in_i.ready = !in_vld_q || dec_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (dec_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.byte_in;
      in_end_q  <= in_i.string_end;
    end
  end

  // decode: sequence state lives here and advances once per consumed byte
  u8u16_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (dec_go),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .res_o  (dec_res)
  );

  // result queue: both halves of a surrogate pair land in one cycle
  u8u16_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dec_go),
    .wr_i    (dec_res),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (q_data)
  );

  assign out_o.code_unit   = q_data.code_unit;
  assign out_o.status      = q_data.status;
  assign out_o.run_last    = q_data.run_last;
  assign out_o.string_done = q_data.string_done;

endmodule
`default_nettype wire

// ===== rtl/u8u16_dec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_dec
// Sequence state and single-pass decode of one registered byte.
// ----------------------------------------------------------------------------
module u8u16_dec (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                go_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                end_i,
  output u8u16_pkg::dec_out_t      res_o
);

  logic [1:0]  rem_q, rem_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] pp_q, pp_d;
  logic        cf_q, cf_d;
  logic        skip_q, skip_d;

  logic [20:0] pp_sh;
  logic        cf_sh;
  logic [1:0]  rem_sh;
  logic [20:0] cp;
  logic [19:0] cp_off;
  logic        bad_scalar;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      len_q  <= '0;
      pp_q   <= '0;
      cf_q   <= 1'b0;
      skip_q <= 1'b0;
    end else if (go_i) begin
      rem_q  <= rem_d;
      len_q  <= len_d;
      pp_q   <= pp_d;
      cf_q   <= cf_d;
      skip_q <= skip_d;
    end
  end

  // continuation step
  assign pp_sh  = {pp_q[14:0], byte_i[5:0]};
  assign cf_sh  = cf_q | (byte_i[7:6] != 2'b10);
  assign rem_sh = rem_q - 2'd1;

  assign cp = (rem_q == 2'd0) ? {13'd0, byte_i} : pp_sh;
  assign cp_off = 20'(cp - u8u16_pkg::PlaneOne);

  assign bad_scalar = ((len_q == 3'd2) && (cp < 21'h80)) ||
                      ((len_q == 3'd3) && (cp < 21'h800)) ||
                      ((len_q == 3'd4) && (cp < u8u16_pkg::PlaneOne)) ||
                      (cp > u8u16_pkg::MaxScalar) ||
                      ((cp >= u8u16_pkg::SurLo) && (cp <= u8u16_pkg::SurHi));

  always_comb begin
    logic                emit;
    logic                err;
    u8u16_pkg::status_e  err_st;

    emit   = 1'b0;
    err    = 1'b0;
    err_st = u8u16_pkg::ST_BAD_LEAD;
    rem_d  = rem_q;
    len_d  = len_q;
    pp_d   = pp_q;
    cf_d   = cf_q;
    skip_d = skip_q;

    if (skip_q) begin
      if (end_i) begin
        skip_d = 1'b0;
        rem_d  = '0;
        len_d  = '0;
        pp_d   = '0;
        cf_d   = 1'b0;
      end
    end else if (rem_q == 2'd0) begin
      case (byte_i) inside
        [8'h00:8'h7f]: emit = 1'b1;
        [8'hc0:8'hdf]: begin
          rem_d = 2'd1; len_d = 3'd2; pp_d = {16'd0, byte_i[4:0]};
        end
        [8'he0:8'hef]: begin
          rem_d = 2'd2; len_d = 3'd3; pp_d = {17'd0, byte_i[3:0]};
        end
        [8'hf0:8'hf7]: begin
          rem_d = 2'd3; len_d = 3'd4; pp_d = {18'd0, byte_i[2:0]};
        end
        default: begin
          err = 1'b1; err_st = u8u16_pkg::ST_BAD_LEAD;
        end
      endcase
      cf_d = 1'b0;
      if (!err && !emit && end_i) begin
        err = 1'b1; err_st = u8u16_pkg::ST_TRUNC;
      end
    end else begin
      rem_d = rem_sh;
      pp_d  = pp_sh;
      cf_d  = cf_sh;
      if (rem_sh != 2'd0) begin
        if (end_i) begin
          err = 1'b1; err_st = u8u16_pkg::ST_TRUNC;
        end
      end else if (cf_sh) begin
        err = 1'b1; err_st = u8u16_pkg::ST_BAD_CONT;
      end else if (bad_scalar) begin
        err = 1'b1; err_st = u8u16_pkg::ST_BAD_SCALAR;
      end else begin
        emit  = 1'b1;
        len_d = '0;
        pp_d  = '0;
      end
    end

    if (err) begin
      rem_d  = '0;
      len_d  = '0;
      pp_d   = '0;
      cf_d   = 1'b0;
      skip_d = !end_i;
    end

    res_o.r0.code_unit   = '0;
    res_o.r0.status      = err_st;
    res_o.r0.run_last    = 1'b1;
    res_o.r0.string_done = 1'b1;
    res_o.r1             = res_o.r0;
    res_o.n_res          = err ? 2'd1 : 2'd0;

    if (emit) begin
      res_o.r0.status = u8u16_pkg::ST_UNIT;
      res_o.r1.status = u8u16_pkg::ST_UNIT;
      if (cp < u8u16_pkg::PlaneOne) begin
        res_o.n_res          = 2'd1;
        res_o.r0.code_unit   = cp[15:0];
        res_o.r0.string_done = end_i;
      end else begin
        res_o.n_res          = 2'd2;
        res_o.r0.code_unit   = {u8u16_pkg::HiSurTag, cp_off[19:10]};
        res_o.r0.run_last    = 1'b0;
        res_o.r0.string_done = 1'b0;
        res_o.r1.code_unit   = {u8u16_pkg::LoSurTag, cp_off[9:0]};
        res_o.r1.string_done = end_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/u8u16_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_fifo
// Result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module u8u16_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire u8u16_pkg::dec_out_t   wr_i,
  output logic                       room_o,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output u8u16_pkg::res_t            data_o
);

  u8u16_pkg::res_t                   mem_q [u8u16_pkg::QDepth];
  logic [u8u16_pkg::QPtrW-1:0]       wp_q, rp_q;
  logic [u8u16_pkg::QCntW-1:0]       cnt_q;
  logic [1:0]                        n_wr;
  logic                              pop;

  assign n_wr    = push_i ? wr_i.n_res : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  // room for a full pair regardless of this cycle's pop
  assign room_o  = (cnt_q <= u8u16_pkg::QCntW'(u8u16_pkg::QDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + u8u16_pkg::QPtrW'(n_wr);
      rp_q  <= rp_q + u8u16_pkg::QPtrW'(pop);
      cnt_q <= cnt_q + u8u16_pkg::QCntW'(n_wr) - u8u16_pkg::QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      mem_q[wp_q] <= wr_i.r0;
    end
    if (n_wr == 2'd2) begin
      mem_q[wp_q + u8u16_pkg::QPtrW'(1)] <= wr_i.r1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/u8u16_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_chk
// Port-level checks on the transcoder's result channel.
// ----------------------------------------------------------------------------
module u8u16_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [15:0] code_unit_i,
  input wire logic [2:0]  status_i,
  input wire logic        run_last_i,
  input wire logic        string_done_i
);

  // error beats carry no unit and close the string
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (status_i != u8u16_pkg::ST_UNIT) |->
      (code_unit_i == 16'd0) && run_last_i && string_done_i)
    else $error("error beat with unit or open string");

  // a non-final beat is always a high surrogate
  a_hi_sur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !run_last_i |->
      (status_i == u8u16_pkg::ST_UNIT) && (code_unit_i[15:10] == u8u16_pkg::HiSurTag)
      && !string_done_i)
    else $error("non-final beat is not a high surrogate");

  // low surrogate follows a taken high surrogate at once
  a_lo_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && !run_last_i |=>
      valid_i && (code_unit_i[15:10] == u8u16_pkg::LoSurTag) && run_last_i)
    else $error("high surrogate not followed by low surrogate");

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(code_unit_i) && $stable(status_i))
    else $error("stalled beat changed");

endmodule

bind utf8_to_utf16_transcoder u8u16_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (out_o.valid),
  .ready_i       (out_o.ready),
  .code_unit_i   (out_o.code_unit),
  .status_i      (out_o.status),
  .run_last_i    (out_o.run_last),
  .string_done_i (out_o.string_done)
);
`default_nettype wire
